### design/crg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crg_pkg: shared definitions for the congruential random generator
// Constants of the prime modulus, the reduction reciprocal, register indexes,
// mode codes and the request/response types of the modular multiplier.
// ----------------------------------------------------------------------------
package crg_pkg;

  localparam int unsigned MODULUS  = 16411;
  localparam int unsigned VAL_W    = 15;
  localparam int unsigned BIN_W    = 4;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned BINS     = 10;
  localparam int unsigned MUL_A    = 17;
  localparam int unsigned ADD_C    = 19;
  localparam int unsigned SQ_D     = 4;
  localparam int unsigned LAG_INIT = 6765;

  // Product width: a*b + c with 15-bit operands stays below 2**30.
  localparam int unsigned P_W      = 2 * VAL_W;
  // Reciprocal scaling: q = (p * RECIP) >> SHIFT lies in floor(p/M)-1 .. floor(p/M).
  localparam int unsigned SHIFT    = P_W + 1;
  localparam longint unsigned RECIP = (64'd1 << SHIFT) / MODULUS;
  localparam int unsigned RECIP_W  = $clog2(RECIP + 1);
  localparam int unsigned Q_W      = $clog2(((64'd1 << P_W) / MODULUS) + 1);
  localparam int unsigned PROD_W   = P_W + RECIP_W;

  // Exponent of the inversion, x^(M-2), scanned from its top bit downwards.
  localparam int unsigned INV_TOP_BIT = $clog2(MODULUS - 2 + 1) - 1;
  localparam int unsigned BIT_W       = $clog2(INV_TOP_BIT + 1);

  // Configuration register indexes.
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SEED = 1'b1;

  // Mode codes; the unused codes step as linear.
  localparam logic [MODE_W-1:0] MODE_LINEAR    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_QUADRATIC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADDITIVE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INVERSE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COMBINED  = 3'd4;

  // Request to the multiplier: r = (a * b + c) mod M.
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] c;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] r;
  } mm_rsp_t;

endpackage
`default_nettype wire

### design/congruential_random_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// congruential_random_generator: five-mode generator modulo the prime 16411
// Each input transaction advances the generator one step and yields one
// output transaction carrying the new value and its decile bin.
// ----------------------------------------------------------------------------
// Usage:
// The configuration port writes the mode (index 0) and the seed (index 1);
// write it only while no transaction is in progress. An input transaction
// (in_valid_i high, in_stall_o low) with in_restart_i set reloads the seed and
// the lag value before stepping. in_stall_o is high from acceptance until the
// result has been moved into the output register.
// All arithmetic runs through one modular multiply-add unit; a pass through
// it is an issue followed by its three stages. A step takes one pass in
// linear and additive mode, two in quadratic, three in combined and nineteen
// in inverse, the latter being an exponentiation by square-and-multiply over
// the 15-bit exponent. The next input transaction is taken only once the
// result has gone into the output register, so no step is accepted before
// the last one is through. The output register holds a finished result
// while out_stall_i is high; the next input transaction is accepted
// meanwhile, but its result waits in the sequencer.
// Reset clears the current value to 0, the lag value to 6765, the mode to
// linear and the seed to 1, and empties the output register.
// ----------------------------------------------------------------------------
module congruential_random_generator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_index_i,
  input  wire logic [crg_pkg::VAL_W-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         in_restart_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [crg_pkg::VAL_W-1:0]         out_value_o,
  output logic [crg_pkg::BIN_W-1:0]         out_bin_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // Micro-operations of the shared unit, each (a * b + c) mod M.
  typedef enum logic [3:0] {
    OP_LIN,    // 17x + 19
    OP_QUAD1,  // 4x + 17
    OP_QUAD2,  // acc * x + 19
    OP_ADD,    // lagged + x
    OP_COMB2,  // aux - acc, as acc * (M - 1) + aux
    OP_LOAD,   // x mod M, start of the exponentiation
    OP_SQR,    // acc * acc
    OP_MULX,   // acc * x
    OP_FINV    // 17 * acc + 19
  } op_e;

  localparam int unsigned          V   = crg_pkg::VAL_W;
  localparam logic [V-1:0]         MOD_V     = V'(crg_pkg::MODULUS);
  localparam logic [V-1:0]         MOD_M1    = V'(crg_pkg::MODULUS - 1);
  localparam logic [V-1:0]         K_A       = V'(crg_pkg::MUL_A);
  localparam logic [V-1:0]         K_C       = V'(crg_pkg::ADD_C);
  localparam logic [V-1:0]         K_D       = V'(crg_pkg::SQ_D);
  localparam logic [V-1:0]         K_ONE     = V'(1);
  localparam logic [V-1:0]         K_ZERO    = '0;
  localparam logic [V-1:0]         LAG_RST   = V'(crg_pkg::LAG_INIT);
  localparam logic [V-1:0]         SEED_RST  = V'(1);
  localparam logic [V-1:0]         INV_EXP   = V'(crg_pkg::MODULUS - 2);
  localparam logic [crg_pkg::BIT_W-1:0] BIT_START = crg_pkg::BIT_W'(crg_pkg::INV_TOP_BIT - 1);
  localparam logic [crg_pkg::BIT_W-1:0] BIT_ZERO  = '0;
  localparam logic [crg_pkg::BIT_W-1:0] BIT_ONE   = crg_pkg::BIT_W'(1);
  localparam logic [crg_pkg::BIN_W-1:0] BIN_MAX   = crg_pkg::BIN_W'(crg_pkg::BINS - 1);

  // Lowest value of each decile bin above the first: ceil(k * M / 10).
  localparam logic [V-1:0] BinEdge [9] = '{
    V'((1 * crg_pkg::MODULUS + crg_pkg::BINS - 1) / crg_pkg::BINS),
    V'((2 * crg_pkg::MODULUS + crg_pkg::BINS - 1) / crg_pkg::BINS),
    V'((3 * crg_pkg::MODULUS + crg_pkg::BINS - 1) / crg_pkg::BINS),
    V'((4 * crg_pkg::MODULUS + crg_pkg::BINS - 1) / crg_pkg::BINS),
    V'((5 * crg_pkg::MODULUS + crg_pkg::BINS - 1) / crg_pkg::BINS),
    V'((6 * crg_pkg::MODULUS + crg_pkg::BINS - 1) / crg_pkg::BINS),
    V'((7 * crg_pkg::MODULUS + crg_pkg::BINS - 1) / crg_pkg::BINS),
    V'((8 * crg_pkg::MODULUS + crg_pkg::BINS - 1) / crg_pkg::BINS),
    V'((9 * crg_pkg::MODULUS + crg_pkg::BINS - 1) / crg_pkg::BINS)
  };

  state_e                         state_d, state_q;
  op_e                            op_d, op_q, op_next, op_first;
  logic [crg_pkg::BIT_W-1:0]      bit_d, bit_q, bit_next;
  logic                           op_last;
  logic [crg_pkg::MODE_W-1:0]     mode_q;
  logic [V-1:0]                   seed_q;
  logic [V-1:0]                   cur_d, cur_q;
  logic [V-1:0]                   lag_d, lag_q;
  logic [V-1:0]                   acc_d, acc_q;
  logic [V-1:0]                   aux_d, aux_q;
  logic                           out_valid_d, out_valid_q;
  logic [V-1:0]                   out_value_q;
  logic [crg_pkg::BIN_W-1:0]      out_bin_d, out_bin_q;
  logic                           in_take;
  logic                           out_free;
  logic                           out_load;
  logic                           uses_lag;
  crg_pkg::mm_req_t               mm_req;
  crg_pkg::mm_rsp_t               mm_rsp;

  crg_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= crg_pkg::MODE_LINEAR;
      seed_q <= SEED_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == crg_pkg::CFG_MODE) begin
        mode_q <= cfg_data_i[crg_pkg::MODE_W-1:0];
      end else begin
        seed_q <= cfg_data_i;
      end
    end
  end

  // First pass of a step, chosen by the mode.
  always_comb begin
    case (mode_q)
      crg_pkg::MODE_QUADRATIC: op_first = OP_QUAD1;
      crg_pkg::MODE_ADDITIVE:  op_first = OP_ADD;
      crg_pkg::MODE_COMBINED:  op_first = OP_ADD;
      crg_pkg::MODE_INVERSE:   op_first = OP_LOAD;
      default:                 op_first = OP_LIN;
    endcase
  end

  assign uses_lag = (mode_q == crg_pkg::MODE_ADDITIVE) || (mode_q == crg_pkg::MODE_COMBINED);

  // Sequencing of the passes. The inversion loads x for the top exponent bit,
  // then squares once per lower bit and multiplies by x where that bit is set.
  always_comb begin
    op_next  = op_q;
    bit_next = bit_q;
    op_last  = 1'b0;
    case (op_q)
      OP_LIN: begin
        if (mode_q == crg_pkg::MODE_COMBINED) begin
          op_next = OP_COMB2;
        end else begin
          op_last = 1'b1;
        end
      end
      OP_QUAD1: op_next = OP_QUAD2;
      OP_QUAD2: op_last = 1'b1;
      OP_ADD: begin
        if (mode_q == crg_pkg::MODE_COMBINED) begin
          op_next = OP_LIN;
        end else begin
          op_last = 1'b1;
        end
      end
      OP_COMB2: op_last = 1'b1;
      OP_LOAD: begin
        op_next  = OP_SQR;
        bit_next = BIT_START;
      end
      OP_SQR: begin
        if (INV_EXP[bit_q]) begin
          op_next = OP_MULX;
        end else if (bit_q == BIT_ZERO) begin
          op_next = OP_FINV;
        end else begin
          bit_next = bit_q - BIT_ONE;
        end
      end
      OP_MULX: begin
        if (bit_q == BIT_ZERO) begin
          op_next = OP_FINV;
        end else begin
          op_next  = OP_SQR;
          bit_next = bit_q - BIT_ONE;
        end
      end
      OP_FINV: op_last = 1'b1;
      default: op_last = 1'b1;
    endcase
  end

  // Operand selection for the shared unit.
  always_comb begin
    mm_req.start = (state_q == ST_ISSUE);
    case (op_q)
      OP_LIN:   begin mm_req.a = K_A;   mm_req.b = cur_q;  mm_req.c = K_C;   end
      OP_QUAD1: begin mm_req.a = K_D;   mm_req.b = cur_q;  mm_req.c = K_A;   end
      OP_QUAD2: begin mm_req.a = acc_q; mm_req.b = cur_q;  mm_req.c = K_C;   end
      OP_ADD:   begin mm_req.a = lag_q; mm_req.b = K_ONE;  mm_req.c = cur_q; end
      OP_COMB2: begin mm_req.a = acc_q; mm_req.b = MOD_M1; mm_req.c = aux_q; end
      OP_LOAD:  begin mm_req.a = cur_q; mm_req.b = K_ONE;  mm_req.c = K_ZERO; end
      OP_SQR:   begin mm_req.a = acc_q; mm_req.b = acc_q;  mm_req.c = K_ZERO; end
      OP_MULX:  begin mm_req.a = acc_q; mm_req.b = cur_q;  mm_req.c = K_ZERO; end
      OP_FINV:  begin mm_req.a = K_A;   mm_req.b = acc_q;  mm_req.c = K_C;   end
      default:  begin mm_req.a = K_A;   mm_req.b = cur_q;  mm_req.c = K_C;   end
    endcase
  end

  // Decile bin: the number of bin edges at or below the value.
  always_comb begin
    out_bin_d = '0;
    for (int k = 0; k < 9; k++) begin
      out_bin_d = out_bin_d + crg_pkg::BIN_W'(acc_q >= BinEdge[k]);
    end
  end

  assign in_take  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    bit_d       = bit_q;
    cur_d       = cur_q;
    lag_d       = lag_q;
    acc_d       = acc_q;
    aux_d       = aux_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if (in_restart_i) begin
            cur_d = seed_q;
            lag_d = LAG_RST;
          end
          op_d    = op_first;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mm_rsp.done) begin
          acc_d = mm_rsp.r;
          aux_d = acc_q;
          if (op_last) begin
            // The lag value takes the state from before this step.
            if (uses_lag) begin
              lag_d = cur_q;
            end
            cur_d   = mm_rsp.r;
            state_d = ST_DONE;
          end else begin
            op_d    = op_next;
            bit_d   = bit_next;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_LIN;
      bit_q       <= BIT_ZERO;
      cur_q       <= K_ZERO;
      lag_q       <= LAG_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      bit_q       <= bit_d;
      cur_q       <= cur_d;
      lag_q       <= lag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    aux_q <= aux_d;
    if (out_load) begin
      out_value_q <= acc_q;
      out_bin_q   <= out_bin_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_bin_o   = out_bin_q;

  // A new result appears only when the sequencer hands one over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("output became valid without a finished step");

  // Results are always fully reduced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_value_q < MOD_V))
    else $error("output value not reduced below the modulus");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_bin_q <= BIN_MAX))
    else $error("decile bin out of range");

  // The multiplier answers only to a pass the sequencer is waiting for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp.done |-> (state_q == ST_WAIT))
    else $error("multiplier response outside the wait state");

endmodule
`default_nettype wire

### design/crg_modmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crg_modmul: three-stage modular multiply-add
// Computes (a * b + c) mod M with a reciprocal quotient estimate and a single
// correcting subtraction. One request may be in flight at a time.
// ----------------------------------------------------------------------------
module crg_modmul (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire crg_pkg::mm_req_t req_i,
  output crg_pkg::mm_rsp_t     rsp_o
);

  localparam logic [crg_pkg::RECIP_W-1:0] RecipK = crg_pkg::RECIP_W'(crg_pkg::RECIP);
  localparam logic [crg_pkg::P_W-1:0]     ModP   = crg_pkg::P_W'(crg_pkg::MODULUS);
  localparam logic [crg_pkg::VAL_W:0]     ModD   = (crg_pkg::VAL_W + 1)'(crg_pkg::MODULUS);

  logic                       s1_q, s2_q, done_q;
  logic [crg_pkg::P_W-1:0]    p_d, p_q, p2_q;
  logic [crg_pkg::Q_W-1:0]    q_d, q_q;
  logic [crg_pkg::PROD_W-1:0] prod;
  logic [crg_pkg::P_W-1:0]    diff;
  logic [crg_pkg::VAL_W:0]    diff_lo;
  logic [crg_pkg::VAL_W-1:0]  r_d, r_q;

  // Stage one: the product and the addend.
  always_comb begin
    p_d = crg_pkg::P_W'(req_i.a) * crg_pkg::P_W'(req_i.b) + crg_pkg::P_W'(req_i.c);
  end

  // Stage two: quotient estimate by the scaled reciprocal.
  always_comb begin
    prod = crg_pkg::PROD_W'(p_q) * crg_pkg::PROD_W'(RecipK);
    q_d  = prod[crg_pkg::SHIFT +: crg_pkg::Q_W];
  end

  // Stage three: the remainder lies below twice the modulus, so one
  // conditional subtraction finishes it.
  always_comb begin
    diff    = p2_q - crg_pkg::P_W'(q_q) * ModP;
    diff_lo = diff[crg_pkg::VAL_W:0];
    if (diff_lo >= ModD) begin
      r_d = crg_pkg::VAL_W'(diff_lo - ModD);
    end else begin
      r_d = crg_pkg::VAL_W'(diff_lo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= req_i.start;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      p_q <= p_d;
    end
    if (s1_q) begin
      q_q  <= q_d;
      p2_q <= p_q;
    end
    if (s2_q) begin
      r_q <= r_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.r    = r_q;

endmodule
`default_nettype wire

### test/tb_congruential_random_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_congruential_random_generator: self-checking bench for the generator
// Walks a directed table of register writes and steps. Rows whose result is
// obvious carry it typed in, and the predictor checks all other steps. A long
// random part follows with random mode and seed settings, random restarts,
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_congruential_random_generator;
  import crg_pkg::*;

  // One result transaction as the bench sees it.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [BIN_W-1:0] bin;
  } gen_result_t;

  // A row of the directed table is either a register write or a generator step.
  typedef enum logic {ROW_WRITE, ROW_STEP} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             cfg_idx;
    logic [VAL_W-1:0] cfg_data;
    logic             restart;
    logic             typed;
    logic [VAL_W-1:0] exp_value;
    logic [BIN_W-1:0] exp_bin;
  } stim_row_t;

  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned MAX_IDLE     = 12;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned N_ROWS       = 46;

  // Directed table. Steps with a typed result are those that follow from a
  // known state: the reset state, the reset seed, and restarts from the seed
  // extremes. All others are checked against the predictor.
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // Reset state: linear mode stepping from zero, then from its own result.
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b1, 15'd19,    4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    // Restart with the reset seed of one.
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b1, 15'd36,    4'd0},
    // The inverse of zero is taken as zero.
    '{ROW_WRITE, CFG_SEED, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_MODE, 15'(MODE_INVERSE),     1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b1, 15'd19,    4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    // A seed equal to the modulus behaves as zero.
    '{ROW_WRITE, CFG_SEED, 15'd16411,             1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b1, 15'd19,    4'd0},
    // Largest seed in linear mode lands in the top bin.
    '{ROW_WRITE, CFG_MODE, 15'(MODE_LINEAR),      1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_SEED, 15'h7FFF,              1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b1, 15'd15495, 4'd9},
    '{ROW_WRITE, CFG_SEED, 15'd16410,             1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b1, 15'd2,     4'd0},
    // Additive lagged mode from a zero seed returns the lag value itself.
    '{ROW_WRITE, CFG_SEED, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_MODE, 15'(MODE_ADDITIVE),    1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b1, 15'd6765,  4'd4},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    // Combined mode: lag value minus the linear step of zero.
    '{ROW_WRITE, CFG_MODE, 15'(MODE_COMBINED),    1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b1, 15'd6746,  4'd4},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_MODE, 15'(MODE_QUADRATIC),   1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b1, 15'd19,    4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    // An out-of-range seed copied into the lag value, then used from there.
    '{ROW_WRITE, CFG_SEED, 15'h7FFF,              1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_MODE, 15'(MODE_ADDITIVE),    1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    // Undefined mode codes, some written with stray upper data bits.
    '{ROW_WRITE, CFG_MODE, 15'h7FFD,              1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_MODE, 15'd6,                 1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_MODE, 15'h4007,              1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    // The inverse of one is one.
    '{ROW_WRITE, CFG_SEED, 15'd1,                 1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_MODE, 15'(MODE_INVERSE),     1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b1, 15'd36,    4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_MODE, 15'(MODE_COMBINED),    1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_SEED, 15'h7FFF,              1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_SEED, 15'd16410,             1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_WRITE, CFG_MODE, 15'(MODE_QUADRATIC),   1'b0, 1'b0, 15'd0,     4'd0},
    '{ROW_STEP,  CFG_MODE, 15'd0,                 1'b1, 1'b0, 15'd0,     4'd0}
  };

  // Every input of the block holds a known value from time zero.
  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_we_i     = 1'b0;
  logic             cfg_index_i  = 1'b0;
  logic [VAL_W-1:0] cfg_data_i   = '0;
  logic             in_valid_i   = 1'b0;
  logic             in_restart_i = 1'b0;
  logic             out_stall_i  = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [VAL_W-1:0] out_value_o;
  logic [BIN_W-1:0] out_bin_o;

  // The bench's own copy of the generator state and its two registers.
  logic [VAL_W-1:0]  gen_current;
  logic [VAL_W-1:0]  gen_lagged;
  logic [MODE_W-1:0] gen_mode;
  logic [VAL_W-1:0]  gen_seed;

  // Results still owed by the block, oldest first.
  gen_result_t pending_results[$];

  int unsigned fail_count        = 0;
  // Set for whole phases to give stretches with no idling on either side.
  bit          no_idle           = 1'b0;
  // Asks the output side for one long hold-off at its next transaction.
  bit          hold_off_pending  = 1'b0;

  congruential_random_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_restart_i (in_restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .out_bin_o    (out_bin_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Reports the first ten failures in full and merely counts the rest.
  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR at %0t ns: %s", $realtime, msg);
    end
  endfunction

  // Advances the bench's generator by one step and returns the value and bin
  // that the block must produce. Arithmetic is done in 64 bits, since the
  // quadratic term of an out-of-range value does not fit in 32 signed bits.
  function automatic void step_generator(input logic restart, output gen_result_t res);
    longint unsigned x;
    longint unsigned acc;
    longint unsigned base;
    longint unsigned linear_step;
    longint unsigned lag_sum;
    int unsigned     expo;
    if (restart) begin
      gen_current = gen_seed;
      gen_lagged  = VAL_W'(LAG_INIT);
    end
    x           = gen_current;
    linear_step = (MUL_A * x + ADD_C) % MODULUS;
    case (gen_mode)
      MODE_QUADRATIC: begin
        acc = (SQ_D * x * x + linear_step) % MODULUS;
      end
      MODE_ADDITIVE: begin
        acc        = (gen_lagged + x) % MODULUS;
        gen_lagged = x[VAL_W-1:0];
      end
      MODE_INVERSE: begin
        // Fermat inverse by square-and-multiply; zero raised to any power stays zero.
        acc  = 1;
        base = x % MODULUS;
        expo = MODULUS - 2;
        while (expo != 0) begin
          if (expo[0]) begin
            acc = (acc * base) % MODULUS;
          end
          base = (base * base) % MODULUS;
          expo = expo >> 1;
        end
        acc = (MUL_A * acc + ADD_C) % MODULUS;
      end
      MODE_COMBINED: begin
        lag_sum    = (gen_lagged + x) % MODULUS;
        gen_lagged = x[VAL_W-1:0];
        acc        = (lag_sum + MODULUS - linear_step) % MODULUS;
      end
      default: begin
        // Linear mode and the three undefined codes.
        acc = linear_step;
      end
    endcase
    gen_current = acc[VAL_W-1:0];
    res.value   = acc[VAL_W-1:0];
    res.bin     = BIN_W'((BINS * acc) / MODULUS);
  endfunction

  // Writes one register and mirrors it into the predictor. Only called while
  // the block is idle. The enable is held for exactly one rising edge.
  task automatic write_register(input logic idx, input logic [VAL_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_MODE) begin
      gen_mode = data[MODE_W-1:0];
    end else begin
      gen_seed = data;
    end
  endtask

  // Offers one input transaction after a random gap and waits for it to be
  // taken. When there is no gap, valid simply stays high from the previous
  // transaction, so it is never lowered and raised within one time step.
  // The expectation is queued at the edge of acceptance.
  task automatic offer_request(input logic restart, input logic typed,
                               input gen_result_t typed_res);
    int unsigned gap;
    gen_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_restart_i <= restart;
    do @(posedge clk_i); while (in_stall_o);
    step_generator(restart, res);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // Stops offering and waits until every owed result has come out, plus a few
  // cycles so that the block is certainly idle before a register write.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Output side: before each transaction it stalls for a random number of
  // cycles, drawn afresh every time, or for one long stretch when asked.
  // That long stretch lets the output register and the sequencer fill up so
  // that the block has to stall its input while the sender keeps offering.
  initial begin : result_sink
    int unsigned hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_pending) begin
        hold             = LONG_HOLD;
        hold_off_pending = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Every output transaction is compared with the oldest expectation. Outputs
  // are read at the rising edge, before the block's own updates land, so the
  // values seen are exactly those that the edge accepts.
  always @(posedge clk_i) begin : result_check
    gen_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with none expected: value %0d bin %0d",
                               out_value_o, out_bin_o));
      end else begin
        want = pending_results.pop_front();
        if (out_value_o !== want.value) begin
          note_failure($sformatf("value mismatch: expected %0d, got %0d",
                                 want.value, out_value_o));
        end
        if (out_bin_o !== want.bin) begin
          note_failure($sformatf("bin mismatch for value %0d: expected %0d, got %0d",
                                 want.value, want.bin, out_bin_o));
        end
      end
    end
  end

  initial begin : stimulus
    gen_result_t       typed_res;
    int unsigned       random_sent;
    int unsigned       phase;
    int unsigned       phase_items;
    int unsigned       pick;
    logic [VAL_W-1:0]  word;
    logic              restart;

    // Predictor starts from the reset state of the block.
    gen_current = '0;
    gen_lagged  = VAL_W'(LAG_INIT);
    gen_mode    = MODE_LINEAR;
    gen_seed    = VAL_W'(1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Register writes wait for the block to fall idle first.
    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        drain_results();
        write_register(DIRECTED[i].cfg_idx, DIRECTED[i].cfg_data);
      end else begin
        typed_res.value = DIRECTED[i].exp_value;
        typed_res.bin   = DIRECTED[i].exp_bin;
        offer_request(DIRECTED[i].restart, DIRECTED[i].typed, typed_res);
      end
    end

    // Random part, in phases. Each phase may change the mode and the seed and
    // then sends a burst of steps, mostly without restart so that the state
    // runs on, with a restart now and then.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain_results();
      no_idle = ($urandom_range(0, 5) == 0);

      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        // The mode sits in the low bits; stray upper bits are sometimes set.
        word = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom) : '0;
        word[MODE_W-1:0] = MODE_W'($urandom_range(0, 7));
        write_register(CFG_MODE, word);
      end

      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          word = VAL_W'($urandom_range(MODULUS, (1 << VAL_W) - 1));
        end else if (pick == 1) begin
          case ($urandom_range(0, 4))
            0:       word = '0;
            1:       word = VAL_W'(1);
            2:       word = VAL_W'(MODULUS - 1);
            3:       word = VAL_W'(MODULUS);
            default: word = '1;
          endcase
        end else begin
          word = VAL_W'($urandom_range(0, MODULUS - 1));
        end
        write_register(CFG_SEED, word);
      end

      phase_items = $urandom_range(4, 40);
      if (phase == 2) begin
        // Back-to-back offers against a long output hold-off.
        hold_off_pending = 1'b1;
        no_idle          = 1'b1;
        phase_items      = 40;
      end

      for (int n = 0; n < phase_items; n++) begin
        restart = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
        offer_request(restart, 1'b0, typed_res);
        random_sent++;
      end
      phase++;
    end

    // Let the last results out, then allow for the slowest step's latency in
    // case anything further comes out that nothing asked for.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit, many times the slowest correct run: every step in inverse mode
  // with full gaps and stalls on both sides, plus the long hold-off.
  initial begin : watchdog
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### congruential_random_generator.f
design/crg_pkg.sv
design/crg_modmul.sv
design/congruential_random_generator.sv
test/tb_congruential_random_generator.sv
